// File: rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
`default_nettype none
package u2u_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W = 16;
	localparam int PART_W = 10;
	localparam int CONT_W = 6;

	localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
	localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
	localparam logic [BYTE_W-1:0] CODE_LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
	localparam logic [BYTE_W-1:0] CODE_LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] MASK_PAY2 = 8'h1F;
	localparam logic [BYTE_W-1:0] MASK_PAY3 = 8'h0F;
	localparam logic [BYTE_W-1:0] MASK_CONT = 8'h3F;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE = 2'd1;
	localparam logic [1:0] PEND_TWO = 2'd2;
	localparam logic [1:0] PEND_SKIP = 2'd3;

	// One input byte as held in the input register.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_string;
	} in_item_t;

endpackage
`default_nettype wire

// File: rtl/u2u_in_stage.sv
// Input register: captures a byte per cycle while s_tready.
`default_nettype none
module u2u_in_stage (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire         [7:0] s_tdata,   // data_byte[7:0]
	input  wire               s_tlast,   // end_of_string
	output logic              valid_s1,
	output u2u_pkg::in_item_t item_s1,
	input  wire               take_s1
);
	import u2u_pkg::*;

	assign s_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_byte <= s_tdata;
			item_s1.end_of_string <= s_tlast;
		end
	end

endmodule
`default_nettype wire

// File: rtl/u2u_decode.sv
// Sequence state update and output register of the decoder.
`default_nettype none
module u2u_decode (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               valid_s1,
	input  u2u_pkg::in_item_t item_s1,
	output logic              take_s1,
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic       [15:0] m_tdata    // code_point[15:0]
);
	import u2u_pkg::*;

	logic [1:0]        pending_q, pending_d;
	logic              skipping_q, skipping_d;
	logic [PART_W-1:0] partial_q, partial_d;
	logic [CP_W-1:0]   acc;
	logic [CP_W-1:0]   cp_d;
	logic              emit;
	logic [BYTE_W-1:0] b;

	// Advance when the output register is free or drains this cycle.
	assign take_s1 = valid_s1 && (!m_tvalid || m_tready);
	assign b = item_s1.data_byte;
	assign acc = {partial_q, b[CONT_W-1:0] & MASK_CONT[CONT_W-1:0]};

	always_comb begin
		pending_d = pending_q;
		skipping_d = skipping_q;
		partial_d = partial_q;
		emit = 1'b0;
		cp_d = acc;
		if (pending_q != PEND_NONE) begin
			pending_d = pending_q - 2'd1;
			if (skipping_q) begin
				if (pending_q == PEND_ONE) begin
					skipping_d = 1'b0;
				end
			end else if (pending_q == PEND_ONE) begin
				emit = 1'b1;
				partial_d = '0;
			end else begin
				partial_d = acc[PART_W-1:0];
			end
		end else if ((b & MASK_ASCII) == '0) begin
			emit = 1'b1;
			cp_d = {{(CP_W-BYTE_W){1'b0}}, b};
		end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
			partial_d = {{(PART_W-BYTE_W){1'b0}}, b & MASK_PAY2};
			pending_d = PEND_ONE;
			skipping_d = 1'b0;
		end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
			partial_d = {{(PART_W-BYTE_W){1'b0}}, b & MASK_PAY3};
			pending_d = PEND_TWO;
			skipping_d = 1'b0;
		end else begin
			// Bad lead: drop it and the next three bytes.
			partial_d = '0;
			pending_d = PEND_SKIP;
			skipping_d = 1'b1;
		end
		if (item_s1.end_of_string) begin
			pending_d = PEND_NONE;
			skipping_d = 1'b0;
			partial_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PEND_NONE;
			skipping_q <= 1'b0;
			partial_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (take_s1) begin
				pending_q <= pending_d;
				skipping_q <= skipping_d;
				partial_q <= partial_d;
			end
			if (take_s1) begin
				m_tvalid <= emit;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && emit) begin
			m_tdata <= cp_d;
		end
	end

`ifndef SYNTHESIS
	a_skip_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		skipping_q |-> pending_q != PEND_NONE)
		else $error("skip flag set with no bytes left to drop");

	a_partial_only_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		partial_q != '0 |-> (pending_q != PEND_NONE && !skipping_q))
		else $error("partial value held outside a sequence");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && item_s1.end_of_string) |=> (pending_q == PEND_NONE && !skipping_q))
		else $error("state not cleared after end of string");

	a_ascii_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && pending_q == PEND_NONE && !item_s1.data_byte[7]) |=> m_tvalid)
		else $error("ASCII byte produced no code point");
`endif

endmodule
`default_nettype wire

// File: rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
`default_nettype none
// Decodes a UTF-8 byte stream into 16-bit code points, one byte per cycle
// sustained while m_tready does not stall the output. Each byte passes an
// input register and one decode step, and the code point that a byte
// completes is then held in the output register. ASCII bytes
// pass through, two- and three-byte sequences are assembled without
// checking continuation bits, and any other lead byte is dropped along
// with the next three bytes. tlast marks the end of a string and discards
// any unfinished sequence after that byte.
module utf8_to_ucs2_decoder (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire   [7:0] s_tdata,   // data_byte[7:0]
	input  wire         s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata    // code_point[15:0]
);
	import u2u_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     take_s1;

	u2u_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (take_s1)
	);

	u2u_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (take_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
